// ===== rtl/core/lstp_pkg.sv =====
// ----------------------------------------------------------------------------
// Lidar scan projector package
// Shared word types, configuration record and rotation constants.
// ----------------------------------------------------------------------------
package lstp_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned XyWidth     = 32;
  localparam int unsigned ZWidth      = 26;

  localparam logic [2:0] RegDisplaySelect = 3'd0;
  localparam logic [2:0] RegStepFirst     = 3'd1;
  localparam logic [2:0] RegStepSecond    = 3'd2;
  localparam logic [2:0] RegMountAngle    = 3'd3;
  localparam logic [2:0] RegOffsetX       = 3'd4;
  localparam logic [2:0] RegOffsetY       = 3'd5;
  localparam logic [2:0] RegImageSize     = 3'd6;

  localparam logic [1:0] ShowBoth   = 2'd0;
  localparam logic [1:0] ShowFirst  = 2'd1;
  localparam logic [1:0] ShowSecond = 2'd2;

  typedef struct packed {
    logic signed [15:0] range_mm;
    logic [11:0]        beam_index;
    logic               sensor_id;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pixel_u;
    logic signed [15:0] pixel_v;
    logic               point_sensor;
  } out_t;

  typedef struct packed {
    logic [1:0]         display_select;
    logic [15:0]        step_first;
    logic [15:0]        step_second;
    logic signed [20:0] mount_angle;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [12:0]        image_size;
  } cfg_t;

  typedef struct packed {
    logic                       valid;
    logic                       sensor;
    logic signed [XyWidth-1:0]  x;
    logic signed [XyWidth-1:0]  y;
    logic signed [ZWidth-1:0]   z;
  } cordic_t;

  function automatic logic signed [ZWidth-1:0] atan_f(input logic [4:0] i);
    logic signed [ZWidth-1:0] r;
    unique case (i)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/lstp_front.sv =====
// ----------------------------------------------------------------------------
// Lidar scan projector front end
// Filters samples, forms and folds the beam angle, applies the rotation gain.
// ----------------------------------------------------------------------------
module lstp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  lstp_pkg::in_t    data_i,
  input  lstp_pkg::cfg_t   cfg_i,
  output lstp_pkg::cordic_t cell_o
);

  localparam logic signed [30:0] AngleBias = 31'sd2396160;
  localparam logic signed [22:0] HalfTurn  = 23'sd737280;
  localparam logic signed [22:0] FullTurn  = 23'sd1474560;
  localparam logic signed [22:0] Quarter   = 23'sd368640;
  localparam logic signed [47:0] GainQ30   = 48'sd652032874;
  localparam int unsigned ZWidthL = lstp_pkg::ZWidth;

  logic keep;
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic s0_q, s1_q, s2_q, s3_q, s4_q;
  logic signed [15:0] r0_q, r1_q, r2_q, r3_q;
  logic [27:0] prod0_q;
  logic [28:0] apos1_q;
  logic [13:0] h2_q;
  logic [14:0] low2_q;
  logic [8:0]  q2_q;
  logic signed [ZWidthL-1:0] z3_q, z4_q;
  logic signed [31:0] x4_q;

  logic [27:0] prod0_d;
  logic signed [30:0] a1_d;
  logic [28:0] qm2_d;
  logic [14:0] qq;
  logic [5:0]  rem3;
  logic signed [22:0] m3;
  logic signed [15:0] r3_d;
  logic signed [47:0] g4;

  always_comb begin
    keep = (data_i.range_mm < 16'sd20000) && (data_i.range_mm > -16'sd20000);
    if (data_i.sensor_id) begin
      keep = keep && (cfg_i.display_select == lstp_pkg::ShowBoth ||
                      cfg_i.display_select == lstp_pkg::ShowSecond);
      prod0_d = 28'(data_i.beam_index) * 28'(cfg_i.step_second);
    end else begin
      keep = keep && (cfg_i.display_select == lstp_pkg::ShowBoth ||
                      cfg_i.display_select == lstp_pkg::ShowFirst);
      prod0_d = 28'(data_i.beam_index) * 28'(cfg_i.step_first);
    end
  end

  always_comb begin
    a1_d = $signed({3'b000, prod0_q}) + AngleBias;
    if (s0_q) begin
      a1_d = a1_d + 31'(cfg_i.mount_angle);
    end
    qm2_d = 29'(apos1_q[28:15]) * 29'd23302;
    qq    = 15'(q2_q) * 15'd45;
    rem3  = 6'(15'(h2_q) - qq);
    m3    = $signed({2'b00, rem3, low2_q});
    r3_d  = r2_q;
    if (m3 >= HalfTurn) begin
      m3 = m3 - FullTurn;
    end
    if (m3 > Quarter) begin
      m3   = m3 - HalfTurn;
      r3_d = -r2_q;
    end else if (m3 < -Quarter) begin
      m3   = m3 + HalfTurn;
      r3_d = -r2_q;
    end
    g4 = 48'(r3_q) * GainQ30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i && keep;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q    <= data_i.sensor_id;
      r0_q    <= data_i.range_mm;
      prod0_q <= prod0_d;
      s1_q    <= s0_q;
      r1_q    <= r0_q;
      apos1_q <= a1_d[28:0];
      s2_q    <= s1_q;
      r2_q    <= r1_q;
      h2_q    <= apos1_q[28:15];
      low2_q  <= apos1_q[14:0];
      q2_q    <= qm2_d[28:20];
      s3_q    <= s2_q;
      r3_q    <= r3_d;
      z3_q    <= ZWidthL'({m3, 4'b0000});
      s4_q    <= s3_q;
      z4_q    <= z3_q;
      x4_q    <= g4[47:16];
    end
  end

  assign cell_o.valid  = v4_q;
  assign cell_o.sensor = s4_q;
  assign cell_o.x      = x4_q;
  assign cell_o.y      = '0;
  assign cell_o.z      = z4_q;

endmodule

// ===== rtl/core/lstp_cell.sv =====
// ----------------------------------------------------------------------------
// Lidar scan projector rotation cell
// One micro-rotation of the vector, handed to the next cell each cycle while enabled.
// ----------------------------------------------------------------------------
module lstp_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  lstp_pkg::cordic_t cell_i,
  output lstp_pkg::cordic_t cell_o
);

  logic signed [lstp_pkg::XyWidth-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [lstp_pkg::ZWidth-1:0]  z_d, z_q, at;
  logic valid_q, sensor_q;

  always_comb begin
    dx = cell_i.y >>> Stage;
    dy = cell_i.x >>> Stage;
    at = lstp_pkg::atan_f(5'(Stage));
    if (cell_i.z >= 0) begin
      x_d = cell_i.x - dx;
      y_d = cell_i.y + dy;
      z_d = cell_i.z - at;
    end else begin
      x_d = cell_i.x + dx;
      y_d = cell_i.y - dy;
      z_d = cell_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sensor_q <= cell_i.sensor;
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
    end
  end

  assign cell_o.valid  = valid_q;
  assign cell_o.sensor = sensor_q;
  assign cell_o.x      = x_q;
  assign cell_o.y      = y_q;
  assign cell_o.z      = z_q;

endmodule

// ===== rtl/core/lstp_back.sv =====
// ----------------------------------------------------------------------------
// Lidar scan projector back end
// Adds the extrinsic offset to second-sensor points, converts to centimetres and forms the pixel.
// ----------------------------------------------------------------------------
module lstp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  lstp_pkg::cordic_t cell_i,
  input  lstp_pkg::cfg_t    cfg_i,
  output logic              valid_o,
  output lstp_pkg::out_t    data_o
);

  localparam logic [19:0] DivBias = 20'd327680;
  localparam logic [39:0] Recip5  = 40'd838861;

  typedef lstp_pkg::out_t out_t_l;

  logic v5_q, v6_q, v7_q, s5_q, s6_q;
  logic signed [16:0] tx5_q, ty5_q;
  logic signed [17:0] qx6_q, qy6_q;
  out_t_l out_q;

  logic signed [31:0] xs, ys;
  logic [19:0] px, py;
  logic [39:0] mx, my;
  logic signed [18:0] u, v, half;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] a);
    logic signed [15:0] r;
    if (a > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (a < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = a[15:0];
    end
    return r;
  endfunction

  always_comb begin
    xs = cell_i.x;
    ys = cell_i.y;
    if (cell_i.sensor) begin
      xs = xs + 32'($signed({cfg_i.offset_x, 14'b0}));
      ys = ys + 32'($signed({cfg_i.offset_y, 14'b0}));
    end
    px   = 20'(tx5_q) + DivBias;
    py   = 20'(ty5_q) + DivBias;
    mx   = 40'(px) * Recip5;
    my   = 40'(py) * Recip5;
    half = $signed({7'b0, cfg_i.image_size[12:1]});
    u    = half + 19'(qx6_q);
    v    = half - 19'(qy6_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= cell_i.valid;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_q  <= cell_i.sensor;
      tx5_q <= xs[31:15];
      ty5_q <= ys[31:15];
      s6_q  <= s5_q;
      qx6_q <= $signed(mx[39:22]) - 18'sd65536;
      qy6_q <= $signed(my[39:22]) - 18'sd65536;
      out_q.pixel_u      <= sat16(u);
      out_q.pixel_v      <= sat16(v);
      out_q.point_sensor <= s6_q;
    end
  end

  assign valid_o = v7_q;
  assign data_o  = out_q;

endmodule

// ===== rtl/core/lidar_scan_to_pixel_projector.sv =====
// ----------------------------------------------------------------------------
// Lidar scan to pixel projector
// Throughput: one word per cycle unless a held output stalls; the whole pipeline advances together.
// Dropped samples leave a bubble and yield no output word.
// Reset clears all stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module lidar_scan_to_pixel_projector (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lstp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lstp_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [20:0]    cfg_data_i
);

  lstp_pkg::cfg_t    cfg_q;
  lstp_pkg::cordic_t chain [lstp_pkg::CordicSteps+1];
  logic en;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_select <= 2'd0;
      cfg_q.step_first     <= 16'd1024;
      cfg_q.step_second    <= 16'd1024;
      cfg_q.mount_angle    <= '0;
      cfg_q.offset_x       <= '0;
      cfg_q.offset_y       <= '0;
      cfg_q.image_size     <= 13'd2200;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lstp_pkg::RegDisplaySelect: cfg_q.display_select <= cfg_data_i[1:0];
        lstp_pkg::RegStepFirst:     cfg_q.step_first     <= cfg_data_i[15:0];
        lstp_pkg::RegStepSecond:    cfg_q.step_second    <= cfg_data_i[15:0];
        lstp_pkg::RegMountAngle:    cfg_q.mount_angle    <= cfg_data_i;
        lstp_pkg::RegOffsetX:       cfg_q.offset_x       <= cfg_data_i[15:0];
        lstp_pkg::RegOffsetY:       cfg_q.offset_y       <= cfg_data_i[15:0];
        lstp_pkg::RegImageSize:     cfg_q.image_size     <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  lstp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .cell_o  (chain[0])
  );

  for (genvar g = 0; g < lstp_pkg::CordicSteps; g++) begin : g_cell
    lstp_cell #(.Stage(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  lstp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cell_i  (chain[lstp_pkg::CordicSteps]),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i) else $error("stall without backpressure");
  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o) else $error("config port not ready");
  a_out_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("output word lost");
`endif

endmodule
